FILE: design/lpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpl_pkg;

    localparam int MAX_CHANNELS  = 8;
    localparam int MAX_LOOKAHEAD = 256;
    localparam int SAMPLE_W      = 16;
    localparam int CH_W          = $clog2(MAX_CHANNELS);
    localparam int PTR_W         = $clog2(MAX_LOOKAHEAD);
    localparam int LEN_W         = 9;
    localparam int CNT_W         = 4;
    localparam int ADDR_W        = CH_W + PTR_W;
    localparam int STORE_DEPTH   = MAX_CHANNELS * MAX_LOOKAHEAD;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int DIV_STEPS     = 15;

    localparam logic [15:0] UNITY_GAIN = 16'd32768;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENV_A,
        S_ENV_B,
        S_ENV_C,
        S_CHECK,
        S_DIV,
        S_GAIN_A,
        S_GAIN_B,
        S_GAIN_C,
        S_OUT_A,
        S_OUT_B
    } t_state;

    // Reduce a channel number modulo the active channel count
    function automatic logic [CH_W-1:0] ch_mod(input logic [CH_W-1:0] ch,
                                               input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] c;
        logic [CNT_W-1:0] r;
        c = cnt;
        if (c == '0) c = CNT_W'(1);
        if (c > CNT_W'(MAX_CHANNELS)) c = CNT_W'(MAX_CHANNELS);
        r = CNT_W'(ch);
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (r >= c) r = r - c;
        end
        return r[CH_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/lpl_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lpl_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [lpl_pkg::SAMPLE_W-1:0] sample_in;
    logic [lpl_pkg::CH_W-1:0]          channel_sel;

    modport source (output valid, output sample_in, output channel_sel, input ready);
    modport sink   (input valid, input sample_in, input channel_sel, output ready);
endinterface
`default_nettype wire

FILE: design/lpl_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lpl_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lpl_pkg::SAMPLE_W-1:0] sample_out;
    logic [15:0]                       envelope_level;
    logic [15:0]                       gain_level;

    modport source (output valid, output sample_out, output envelope_level,
                    output gain_level, input ready);
    modport sink   (input valid, input sample_out, input envelope_level,
                    input gain_level, output ready);
endinterface
`default_nettype wire

FILE: design/lpl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lpl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read one word per cycle and write it when enabled, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: design/lookahead_peak_limiter.sv
`timescale 1ns / 1ps
`default_nettype none
// Multichannel lookahead peak limiter. An item (Q1.15 sample, channel) passes
// the envelope filter, a ceiling check, the ceiling/envelope division when the
// envelope exceeds the ceiling (one quotient bit a cycle), the gain filter and
// the output product. Ready is high again in the cycle the result appears, so
// the next item can be accepted then, but not before. A result that is still
// waiting holds the next item in its last step. A sequencer runs both filters
// and the output product through one shared 18x18 multiplier and the division
// through a restoring divider; ready is low while an item is in work. The delay
// lines live in one single-port RAM; writing lookahead_length or channel_count
// empties them at once (a per-channel wrap flag masks stale words), so no
// clearing pass is needed. Envelopes and gains are kept across such writes.
module lookahead_peak_limiter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lpl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [lpl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lpl_in_if.sink                               i_in,
    lpl_out_if.source                            o_out
);
    localparam int CH_W  = lpl_pkg::CH_W;
    localparam int PTR_W = lpl_pkg::PTR_W;
    localparam int LEN_W = lpl_pkg::LEN_W;
    localparam int NCH   = lpl_pkg::MAX_CHANNELS;

    // configuration
    logic [15:0]              r_attack, r_release, r_ceiling;
    logic [LEN_W-1:0]         r_len;
    logic [lpl_pkg::CNT_W-1:0] r_cnt_ch;

    // per-channel state
    logic [PTR_W-1:0] r_ptr   [NCH];
    logic             r_full  [NCH];
    logic [15:0]      r_env   [NCH];
    logic [15:0]      r_gain  [NCH];

    // item in work
    lpl_pkg::t_state            r_state, n_state;
    logic signed [15:0]         r_x;
    logic [15:0]                r_ax;
    logic [CH_W-1:0]            r_ch;
    logic [PTR_W-1:0]           r_cur_ptr;
    logic                       r_cur_full;
    logic [15:0]                r_env_old, r_gain_old, r_env_new, r_gain_new;
    logic [15:0]                r_coef, r_target, r_desired;
    logic signed [15:0]         r_delayed;
    logic [16:0]                r_rem;
    logic [3:0]                 r_step;
    logic [33:0]                r_acc;
    logic signed [35:0]         r_prod;

    // output register
    logic                       r_o_valid;
    logic signed [15:0]         r_o_sample;
    logic [15:0]                r_o_env, r_o_gain;

    logic signed [17:0] mul_a, mul_b;
    logic               accept, advance, cfg_clear;
    logic [CH_W-1:0]    ch_in;
    logic [15:0]        ax_in;
    logic [33:0]        sum;
    logic [17:0]        rem2;
    logic [LEN_W-1:0]   len_eff, ptr_inc;
    logic signed [35:0] rounded;
    logic signed [20:0] y_full;
    logic signed [15:0] y_sat;
    logic               ram_we;
    logic [lpl_pkg::ADDR_W-1:0] ram_addr;
    logic [15:0]        ram_rdata;

    assign accept    = i_in.valid && i_in.ready;
    assign advance   = (r_state == lpl_pkg::S_OUT_B) && (!r_o_valid || o_out.ready);
    assign cfg_clear = i_cfg_we && (i_cfg_idx == lpl_pkg::CFG_LOOKAHEAD
                                    || i_cfg_idx == lpl_pkg::CFG_CHANNELS);
    assign ch_in     = lpl_pkg::ch_mod(i_in.channel_sel, r_cnt_ch);
    assign ax_in     = i_in.sample_in[15] ? 16'(-$signed({i_in.sample_in[15], i_in.sample_in}))
                                          : 16'(i_in.sample_in);
    assign sum       = r_acc + r_prod[33:0];
    assign rem2      = {r_rem, 1'b0};

    always_comb begin
        if (r_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_len > LEN_W'(lpl_pkg::MAX_LOOKAHEAD)) begin
            len_eff = LEN_W'(lpl_pkg::MAX_LOOKAHEAD);
        end else begin
            len_eff = r_len;
        end
    end
    assign ptr_inc = LEN_W'(r_cur_ptr) + LEN_W'(1);

    // round, shift and saturate the output product
    assign rounded = r_prod + 36'sd16384;
    assign y_full  = 21'(rounded >>> 15);
    always_comb begin
        if (y_full > 21'sd32767) begin
            y_sat = 16'sh7FFF;
        end else if (y_full < -21'sd32768) begin
            y_sat = 16'sh8000;
        end else begin
            y_sat = y_full[15:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpl_pkg::S_IDLE:   if (accept) n_state = lpl_pkg::S_ENV_A;
            lpl_pkg::S_ENV_A:  n_state = lpl_pkg::S_ENV_B;
            lpl_pkg::S_ENV_B:  n_state = lpl_pkg::S_ENV_C;
            lpl_pkg::S_ENV_C:  n_state = lpl_pkg::S_CHECK;
            lpl_pkg::S_CHECK:  n_state = (r_env_new > r_ceiling) ? lpl_pkg::S_DIV
                                                                : lpl_pkg::S_GAIN_A;
            lpl_pkg::S_DIV:    if (r_step == 4'(lpl_pkg::DIV_STEPS - 1))
                                   n_state = lpl_pkg::S_GAIN_A;
            lpl_pkg::S_GAIN_A: n_state = lpl_pkg::S_GAIN_B;
            lpl_pkg::S_GAIN_B: n_state = lpl_pkg::S_GAIN_C;
            lpl_pkg::S_GAIN_C: n_state = lpl_pkg::S_OUT_A;
            lpl_pkg::S_OUT_A:  n_state = lpl_pkg::S_OUT_B;
            lpl_pkg::S_OUT_B:  if (advance) n_state = lpl_pkg::S_IDLE;
            default:           n_state = lpl_pkg::S_IDLE;
        endcase
    end

    // multiplier operands, RAM port and handshake
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            lpl_pkg::S_ENV_A: begin
                mul_a = {2'b00, (r_ax > r_env_old) ? r_attack : r_release};
                mul_b = {2'b00, r_env_old};
            end
            lpl_pkg::S_ENV_B: begin
                mul_a = {1'b0, 17'(17'h10000 - {1'b0, r_coef})};
                mul_b = {2'b00, r_ax};
            end
            lpl_pkg::S_GAIN_A: begin
                mul_a = {2'b00, r_release};
                mul_b = {2'b00, r_gain_old};
            end
            lpl_pkg::S_GAIN_B: begin
                mul_a = {1'b0, 17'(17'h10000 - {1'b0, r_release})};
                mul_b = {2'b00, r_target};
            end
            // keep the output product while the result waits
            lpl_pkg::S_OUT_A, lpl_pkg::S_OUT_B: begin
                mul_a = 18'(r_delayed);
                mul_b = {2'b00, r_gain_new};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        ram_we   = advance;
        ram_addr = (r_state == lpl_pkg::S_IDLE)
                 ? {ch_in, (cfg_clear ? PTR_W'(0) : r_ptr[ch_in])}
                 : {r_ch, r_cur_ptr};
        i_in.ready = (r_state == lpl_pkg::S_IDLE);
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.sample_out     = r_o_sample;
    assign o_out.envelope_level = r_o_env;
    assign o_out.gain_level     = r_o_gain;

    lpl_ram #(.WIDTH(16), .DEPTH(lpl_pkg::STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_x),
        .o_rdata (ram_rdata)
    );

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lpl_pkg::S_IDLE;
            r_o_valid <= 1'b0;
            r_attack  <= 16'd0;
            r_release <= 16'd65000;
            r_ceiling <= 16'd32768;
            r_len     <= LEN_W'(48);
            r_cnt_ch  <= 4'd1;
            for (int i = 0; i < NCH; i++) begin
                r_ptr[i]  <= '0;
                r_full[i] <= 1'b0;
                r_env[i]  <= '0;
                r_gain[i] <= lpl_pkg::UNITY_GAIN;
            end
        end else begin
            r_state <= n_state;
            // hold the result until taken
            if (advance) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lpl_pkg::CFG_ATTACK:    r_attack  <= i_cfg_data;
                    lpl_pkg::CFG_RELEASE:   r_release <= i_cfg_data;
                    lpl_pkg::CFG_CEILING:   r_ceiling <= i_cfg_data;
                    lpl_pkg::CFG_LOOKAHEAD: r_len     <= i_cfg_data[LEN_W-1:0];
                    lpl_pkg::CFG_CHANNELS:  r_cnt_ch  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            // commit channel state at the end of an item
            if (advance) begin
                r_env[r_ch]  <= r_env_new;
                r_gain[r_ch] <= r_gain_new;
                if (ptr_inc >= len_eff) begin
                    r_ptr[r_ch]  <= '0;
                    r_full[r_ch] <= 1'b1;
                end else begin
                    r_ptr[r_ch] <= ptr_inc[PTR_W-1:0];
                end
            end
            // drop all delay contents on a geometry change
            if (cfg_clear) begin
                for (int i = 0; i < NCH; i++) begin
                    r_ptr[i]  <= '0;
                    r_full[i] <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            lpl_pkg::S_IDLE: begin
                if (accept) begin
                    r_x        <= i_in.sample_in;
                    r_ax       <= ax_in;
                    r_ch       <= ch_in;
                    r_cur_ptr  <= r_ptr[ch_in];
                    r_cur_full <= r_full[ch_in];
                    r_env_old  <= r_env[ch_in];
                    r_gain_old <= r_gain[ch_in];
                end
            end
            lpl_pkg::S_ENV_A: begin
                r_delayed <= r_cur_full ? ram_rdata : 16'sd0;
                r_coef    <= (r_ax > r_env_old) ? r_attack : r_release;
            end
            lpl_pkg::S_ENV_B: r_acc <= r_prod[33:0] + 34'd32768;
            lpl_pkg::S_ENV_C: r_env_new <= sum[31:16];
            lpl_pkg::S_CHECK: begin
                r_rem     <= {1'b0, r_ceiling};
                r_step    <= '0;
                r_desired <= (r_env_new > r_ceiling) ? 16'd0 : lpl_pkg::UNITY_GAIN;
            end
            lpl_pkg::S_DIV: begin
                // one quotient bit per cycle
                r_step <= r_step + 4'd1;
                if (rem2 >= {2'b00, r_env_new}) begin
                    r_rem     <= 17'(rem2 - {2'b00, r_env_new});
                    r_desired <= {r_desired[14:0], 1'b1};
                end else begin
                    r_rem     <= rem2[16:0];
                    r_desired <= {r_desired[14:0], 1'b0};
                end
            end
            lpl_pkg::S_GAIN_A: r_target <= (r_desired < r_gain_old) ? r_desired : r_gain_old;
            lpl_pkg::S_GAIN_B: r_acc <= r_prod[33:0] + 34'd32768;
            lpl_pkg::S_GAIN_C: r_gain_new <= sum[31:16];
            lpl_pkg::S_OUT_A: ;
            lpl_pkg::S_OUT_B: begin
                if (advance) begin
                    r_o_sample <= y_sat;
                    r_o_env    <= r_env_new;
                    r_o_gain   <= r_gain_new;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: design/lpl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lpl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_sample_out,
    input wire logic [15:0] i_env,
    input wire logic [15:0] i_gain
);
    // busy after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready high right after an accepted item");

    // a stalled result stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_sample_out))
        else $error("stalled result dropped or changed");

    // envelope and gain stay within unity
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_env <= 16'd32768) && (i_gain <= 16'd32768))
        else $error("envelope or gain above unity");

    // no result appears without an item in work
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !i_in_ready || $past(!i_in_ready))
        else $error("result without an item");
endmodule

bind lookahead_peak_limiter lpl_checker u_lpl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_sample_out (o_out.sample_out),
    .i_env        (o_out.envelope_level),
    .i_gain       (o_out.gain_level)
);
`default_nettype wire
